### hdl/lsw_pkg.sv
`timescale 1ns / 1ps

package lsw_pkg;

  // Coordinate and arithmetic widths fixed by the item format.
  localparam int COORD_W = 6;
  localparam int DIFF_W = 7;
  localparam int ERR_W = 9;

  // Defaults for the top-level parameters.
  localparam int GRID_SIZE_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Kind of work that the front hands to the back.
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_TRACE = 1'b1
  } lsw_cmd_e;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WR_WB,
    ST_WALK
  } lsw_state_e;

  // Input request as it arrives on the port.
  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] row_a;
    logic [COORD_W-1:0] col_a;
    logic [COORD_W-1:0] row_b;
    logic [COORD_W-1:0] col_b;
    logic               wall_bit;
  } lsw_in_t;

  // One visited cell as it leaves the block.
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               hit_wall;
    logic               reached_end;
    logic               last;
  } lsw_out_t;

  // Classified request with the line setup already worked out.
  typedef struct packed {
    lsw_cmd_e                  kind;
    logic [COORD_W-1:0]        row_a;
    logic [COORD_W-1:0]        col_a;
    logic [COORD_W-1:0]        row_b;
    logic [COORD_W-1:0]        col_b;
    logic                      wall_bit;
    logic                      col_major;
    logic                      maj_pos;
    logic                      step_r;
    logic                      neg_r;
    logic                      step_c;
    logic                      neg_c;
    logic [DIFF_W-1:0]         d_maj;
    logic [DIFF_W-1:0]         d_min;
    logic signed [ERR_W-1:0]   err0;
  } lsw_task_t;

endpackage

### hdl/lsw_front.sv
`timescale 1ns / 1ps

module lsw_front #(
  parameter int GRID_SIZE = lsw_pkg::GRID_SIZE_DEF
) (
  input  lsw_pkg::lsw_in_t   in_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               push_o,
  output lsw_pkg::lsw_task_t push_task_o,
  input  logic               push_ready_i
);
  import lsw_pkg::*;

  localparam logic [COORD_W:0] GRID_LIM = (COORD_W + 1)'(GRID_SIZE);

  logic signed [DIFF_W-1:0] dr_s;
  logic signed [DIFF_W-1:0] dc_s;
  logic [DIFF_W-1:0]        dr_abs;
  logic [DIFF_W-1:0]        dc_abs;
  logic [DIFF_W-1:0]        d_r;
  logic [DIFF_W-1:0]        d_c;
  logic [DIFF_W-1:0]        abs_maj;
  logic                     col_major;
  logic                     wr_in_grid;
  logic                     drop;

  // Signed deltas and their magnitudes, doubled for the error term.
  always_comb begin
    dr_s = $signed({1'b0, in_data_i.row_b}) - $signed({1'b0, in_data_i.row_a});
    dc_s = $signed({1'b0, in_data_i.col_b}) - $signed({1'b0, in_data_i.col_a});
    dr_abs = dr_s[DIFF_W-1] ? DIFF_W'(-dr_s) : DIFF_W'(dr_s);
    dc_abs = dc_s[DIFF_W-1] ? DIFF_W'(-dc_s) : DIFF_W'(dc_s);
    d_r = {dr_abs[DIFF_W-2:0], 1'b0};
    d_c = {dc_abs[DIFF_W-2:0], 1'b0};
    col_major = (d_c >= d_r);
    abs_maj = col_major ? dc_abs : dr_abs;
  end

  // Build the task record for the back end.
  always_comb begin
    push_task_o.kind      = in_data_i.mode ? CMD_TRACE : CMD_WRITE;
    push_task_o.row_a     = in_data_i.row_a;
    push_task_o.col_a     = in_data_i.col_a;
    push_task_o.row_b     = in_data_i.row_b;
    push_task_o.col_b     = in_data_i.col_b;
    push_task_o.wall_bit  = in_data_i.wall_bit;
    push_task_o.col_major = col_major;
    push_task_o.step_r    = (dr_s != '0);
    push_task_o.neg_r     = dr_s[DIFF_W-1];
    push_task_o.step_c    = (dc_s != '0);
    push_task_o.neg_c     = dc_s[DIFF_W-1];
    push_task_o.maj_pos   = col_major ? ((dc_s != '0) && !dc_s[DIFF_W-1])
                                      : ((dr_s != '0) && !dr_s[DIFF_W-1]);
    push_task_o.d_maj     = col_major ? d_c : d_r;
    push_task_o.d_min     = col_major ? d_r : d_c;
    push_task_o.err0      = $signed({2'b00, push_task_o.d_min})
                          - $signed({3'b000, abs_maj[COORD_W-1:0]});
  end

  // A wall write outside the grid is taken and then discarded.
  always_comb begin
    wr_in_grid = ({1'b0, in_data_i.row_a} < GRID_LIM) && ({1'b0, in_data_i.col_a} < GRID_LIM);
    drop = !in_data_i.mode && !wr_in_grid;
    in_ready_o = push_ready_i;
    push_o = in_valid_i && push_ready_i && !drop;
  end

endmodule

### hdl/lsw_queue.sv
`timescale 1ns / 1ps

module lsw_queue #(
  parameter int DEPTH = lsw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lsw_pkg::lsw_task_t push_task_i,
  output logic               push_ready_o,
  output logic               pop_valid_o,
  output lsw_pkg::lsw_task_t pop_task_o,
  input  logic               pop_ready_i
);
  import lsw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lsw_task_t        slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  // Handshake and pointer bookkeeping.
  always_comb begin
    push_ready_o = (cnt_q != CNT_FULL);
    pop_valid_o = (cnt_q != '0);
    pop_task_o = slot_q[rd_ptr_q];
    do_push = push_i && push_ready_o;
    do_pop = pop_valid_o && pop_ready_i;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_task_i;
    end
  end

endmodule

### hdl/lsw_back.sv
`timescale 1ns / 1ps

module lsw_back #(
  parameter int GRID_SIZE = lsw_pkg::GRID_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  lsw_pkg::lsw_task_t q_task_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lsw_pkg::lsw_out_t  out_data_o
);
  import lsw_pkg::*;

  localparam int IDX_W = $clog2(GRID_SIZE);
  localparam logic [COORD_W:0] GRID_LIM = (COORD_W + 1)'(GRID_SIZE);

  lsw_state_e state_q, state_d;

  lsw_task_t          task_q, task_d;
  logic [COORD_W-1:0] cur_r_q, cur_r_d;
  logic [COORD_W-1:0] cur_c_q, cur_c_d;
  logic [ERR_W-1:0]   err_q, err_d;
  logic               first_q, first_d;

  logic [GRID_SIZE-1:0] wall_mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] rdata_q;
  logic                 row_ok_q, row_ok_d;
  logic [GRID_SIZE-1:0] row_vld_q;
  logic [GRID_SIZE-1:0] old_row;
  logic [GRID_SIZE-1:0] new_row;

  lsw_out_t out_q, out_d;
  logic     out_valid_q, out_valid_d;
  logic     out_free;

  logic pop;
  logic emit;
  logic mem_we;

  logic             wall;
  logic             at_end;
  logic             terminal;
  logic             minor_step;
  logic             move_r;
  logic             move_c;
  logic [ERR_W:0]   err_sum;
  logic [COORD_W-1:0] r_next;
  logic [COORD_W-1:0] c_next;

  // Wall test for the current cell; out-of-grid cells are never walls.
  always_comb begin
    wall = row_ok_q && ({1'b0, cur_c_q} < GRID_LIM) && rdata_q[cur_c_q[IDX_W-1:0]];
    if (first_q) begin
      at_end = (cur_r_q == task_q.row_b) && (cur_c_q == task_q.col_b);
    end else begin
      at_end = task_q.col_major ? (cur_c_q == task_q.col_b) : (cur_r_q == task_q.row_b);
    end
    terminal = wall || at_end;
  end

  // One Bresenham step; a zero error moves the minor axis only when the
  // major axis runs in the positive direction.
  always_comb begin
    minor_step = !err_q[ERR_W-1] && ((err_q != '0) || task_q.maj_pos);
    move_r = task_q.col_major ? minor_step : 1'b1;
    move_c = task_q.col_major ? 1'b1 : minor_step;
    err_sum = {err_q[ERR_W-1], err_q}
            - (minor_step ? (ERR_W + 1)'(task_q.d_maj) : '0)
            + (ERR_W + 1)'(task_q.d_min);
    r_next = cur_r_q;
    c_next = cur_c_q;
    if (move_r && task_q.step_r) begin
      r_next = task_q.neg_r ? cur_r_q - 1'b1 : cur_r_q + 1'b1;
    end
    if (move_c && task_q.step_c) begin
      c_next = task_q.neg_c ? cur_c_q - 1'b1 : cur_c_q + 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = (q_task_i.kind == CMD_WRITE) ? ST_WR_WB : ST_WALK;
        end
      end
      ST_WR_WB: begin
        state_d = ST_IDLE;
      end
      ST_WALK: begin
        if (out_free && terminal) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    q_ready_o = 1'b0;
    emit = 1'b0;
    mem_we = 1'b0;
    case (state_q)
      ST_IDLE:  q_ready_o = 1'b1;
      ST_WR_WB: mem_we = 1'b1;
      ST_WALK:  emit = out_free;
      default:  q_ready_o = 1'b0;
    endcase
    pop = q_ready_o && q_valid_i;
  end

  // Walk registers and the read address that follows them.
  always_comb begin
    task_d = task_q;
    cur_r_d = cur_r_q;
    cur_c_d = cur_c_q;
    err_d = err_q;
    first_d = first_q;
    if (pop) begin
      task_d = q_task_i;
      cur_r_d = q_task_i.row_a;
      cur_c_d = q_task_i.col_a;
      err_d = q_task_i.err0;
      first_d = 1'b1;
    end else if (emit && !terminal) begin
      cur_r_d = r_next;
      cur_c_d = c_next;
      err_d = err_sum[ERR_W-1:0];
      first_d = 1'b0;
    end
    row_ok_d = ({1'b0, cur_r_d} < GRID_LIM) && row_vld_q[cur_r_d[IDX_W-1:0]];
  end

  // Result register in front of the output port.
  always_comb begin
    out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (emit) begin
      out_d.row = cur_r_q;
      out_d.col = cur_c_q;
      out_d.hit_wall = wall;
      out_d.reached_end = terminal && !wall;
      out_d.last = terminal;
      out_valid_d = 1'b1;
    end
    out_valid_o = out_valid_q;
    out_data_o = out_q;
  end

  // Merge one wall bit into the row read back from the map.
  always_comb begin
    old_row = row_ok_q ? rdata_q : '0;
    for (int i = 0; i < GRID_SIZE; i++) begin
      new_row[i] = (cur_c_q[IDX_W-1:0] == IDX_W'(i)) ? task_q.wall_bit : old_row[i];
    end
  end

  // Control registers; a cleared row-valid bit reads its row as all zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
      row_vld_q <= '0;
      row_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      row_ok_q <= row_ok_d;
      if (mem_we) begin
        row_vld_q[cur_r_q[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    task_q <= task_d;
    cur_r_q <= cur_r_d;
    cur_c_q <= cur_c_d;
    err_q <= err_d;
    first_q <= first_d;
    out_q <= out_d;
  end

  // Wall map: one row-wide port, registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wall_mem[cur_r_q[IDX_W-1:0]] <= new_row;
    end
    rdata_q <= wall_mem[cur_r_d[IDX_W-1:0]];
  end

endmodule

### hdl/line_of_sight_walker_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_data_i   (lsw_in_t)
// out       output     out_valid_o / out_ready_i out_data_o  (lsw_out_t)
//
// A trace request loads its task into the walker and then visits the cells of
// its line, up to 64 of them; the walker emits one cell per cycle while the
// output is not stalled, limited by the single read port of the wall map.
// A wall write reads the row, then writes the row back.
// Reset clears the wall map at once through per-row valid bits; no sweep.
// A stalled output holds the walker on its current cell while the front
// keeps taking requests until its queue is full.

module line_of_sight_walker_unit #(
  parameter int GRID_SIZE = lsw_pkg::GRID_SIZE_DEF,
  parameter int QUEUE_DEPTH = lsw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lsw_pkg::lsw_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lsw_pkg::lsw_out_t out_data_o
);
  import lsw_pkg::*;

  logic      push;
  logic      push_ready;
  lsw_task_t push_task;
  logic      pop_valid;
  logic      pop_ready;
  lsw_task_t pop_task;

  // Accept and classify requests.
  lsw_front #(
    .GRID_SIZE(GRID_SIZE)
  ) u_front (
    .in_data_i   (in_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .push_o      (push),
    .push_task_o (push_task),
    .push_ready_i(push_ready)
  );

  // Decoupling queue between front and back.
  lsw_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_task_i (push_task),
    .push_ready_o(push_ready),
    .pop_valid_o (pop_valid),
    .pop_task_o  (pop_task),
    .pop_ready_i (pop_ready)
  );

  // Wall map and line walker.
  lsw_back #(
    .GRID_SIZE(GRID_SIZE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (pop_valid),
    .q_ready_o  (pop_ready),
    .q_task_i   (pop_task),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

### dv/lsw_trace_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the line-of-sight walker. It keeps its own wall
// grid, works out the cells that every accepted trace request must visit, and
// compares each result against the oldest cell still owed.
module lsw_trace_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  lsw_pkg::lsw_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  lsw_pkg::lsw_out_t out_data_i,
  output int                mismatch_count_o,
  output int                cells_owed_o,
  output int                cells_checked_o
);
  import lsw_pkg::*;

  localparam int GRID = GRID_SIZE_DEF;

  // Shadow copy of the wall map and the cells still owed by the block.
  logic     wall_grid [GRID][GRID];
  lsw_out_t owed_cells [$];
  int       mismatches;
  int       checked;

  function automatic logic wall_at(input int r, input int c);
    if (r < 0 || c < 0 || r >= GRID || c >= GRID) begin
      return 1'b0;
    end
    return wall_grid[r][c];
  endfunction

  function automatic void owe_cell(input int r, input int c, input logic wall,
                                   input logic reached, input logic fin);
    lsw_out_t pend;
    pend.row         = COORD_W'(r);
    pend.col         = COORD_W'(c);
    pend.hit_wall    = wall;
    pend.reached_end = reached;
    pend.last        = fin;
    owed_cells.insert(owed_cells.size(), pend);
  endfunction

  // Bresenham walk at doubled error. On a zero error the minor axis only
  // moves when the major axis steps in the positive direction.
  function automatic void walk_line(input lsw_in_t req);
    int   r, c, rb, cb, dr, dc, ir, ic, err;
    logic wall;
    r  = req.row_a;
    c  = req.col_a;
    rb = req.row_b;
    cb = req.col_b;
    dc = cb - c;
    ic = (dc > 0) ? 1 : ((dc < 0) ? -1 : 0);
    dc = ((dc < 0) ? -dc : dc) * 2;
    dr = rb - r;
    ir = (dr > 0) ? 1 : ((dr < 0) ? -1 : 0);
    dr = ((dr < 0) ? -dr : dr) * 2;

    // The start cell ends the walk when it is a wall or already the end.
    wall = wall_at(r, c);
    if (wall || (r == rb && c == cb)) begin
      owe_cell(r, c, wall, !wall, 1'b1);
      return;
    end
    owe_cell(r, c, 1'b0, 1'b0, 1'b0);

    if (dc >= dr) begin
      err = dr - dc / 2;
      while (c != cb) begin
        if (err > 0 || (err == 0 && ic > 0)) begin
          err -= dc;
          r += ir;
        end
        err += dr;
        c += ic;
        wall = wall_at(r, c);
        if (wall || c == cb) begin
          owe_cell(r, c, wall, !wall, 1'b1);
          return;
        end
        owe_cell(r, c, 1'b0, 1'b0, 1'b0);
      end
    end else begin
      err = dc - dr / 2;
      while (r != rb) begin
        if (err > 0 || (err == 0 && ir > 0)) begin
          err -= dr;
          c += ic;
        end
        err += dc;
        r += ir;
        wall = wall_at(r, c);
        if (wall || r == rb) begin
          owe_cell(r, c, wall, !wall, 1'b1);
          return;
        end
        owe_cell(r, c, 1'b0, 1'b0, 1'b0);
      end
    end
  endfunction

  function automatic void check_field(input string name, input int exp_val,
                                      input int act_val);
    if (exp_val != act_val) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
               act_val);
    end
  endfunction

  // Predict on every accepted request, then check every accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    lsw_out_t exp_cell;
    if (!rst_ni) begin
      foreach (wall_grid[r, c]) begin
        wall_grid[r][c] = 1'b0;
      end
      owed_cells.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.mode == CMD_WRITE) begin
          if (in_data_i.row_a < GRID && in_data_i.col_a < GRID) begin
            wall_grid[in_data_i.row_a][in_data_i.col_a] = in_data_i.wall_bit;
          end
        end else begin
          walk_line(in_data_i);
        end
      end
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (owed_cells.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected cell, expected none, actual row %0d col %0d",
                   $time, out_data_i.row, out_data_i.col);
        end else begin
          exp_cell = owed_cells.pop_front();
          check_field("row", exp_cell.row, out_data_i.row);
          check_field("col", exp_cell.col, out_data_i.col);
          check_field("hit_wall", exp_cell.hit_wall, out_data_i.hit_wall);
          check_field("reached_end", exp_cell.reached_end, out_data_i.reached_end);
          check_field("last", exp_cell.last, out_data_i.last);
        end
      end
    end
    mismatch_count_o <= mismatches;
    cells_owed_o     <= owed_cells.size();
    cells_checked_o  <= checked;
  end

endmodule

### dv/line_of_sight_walker_unit_tb.sv
`timescale 1ns / 1ps

module line_of_sight_walker_unit_tb;
  import lsw_pkg::*;

  localparam int IN_W = $bits(lsw_in_t);
  localparam int PHASE_ITEMS = 165;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  lsw_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  lsw_out_t out_data;

  int mismatch_count;
  int cells_owed;
  int cells_checked;

  int send_idle_pct = 23;
  int recv_idle_pct = 48;
  logic hold_output = 1'b0;
  int cycle_count = 0;
  int traces_sent = 0;
  int writes_sent = 0;
  logic [COORD_W-1:0] last_wr_row = '0;
  logic [COORD_W-1:0] last_wr_col = '0;

  line_of_sight_walker_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  lsw_trace_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatch_count),
    .cells_owed_o     (cells_owed),
    .cells_checked_o  (cells_checked)
  );

  // Clock and a single reset at the start.
  always #1 clk_i = ~clk_i;

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Runaway guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d cells owed.", cycle_count,
               cells_owed);
      $display("line_of_sight_walker_unit_tb: errors");
      $finish;
    end
  end

  // Receiver side: random back-pressure, plus one long hold on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_output = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic lsw_in_t wall_req(input int r, input int c, input logic wall);
    lsw_in_t req;
    req          = IN_W'($urandom);
    req.mode     = CMD_WRITE;
    req.row_a    = COORD_W'(r);
    req.col_a    = COORD_W'(c);
    req.wall_bit = wall;
    return req;
  endfunction

  function automatic lsw_in_t trace_req(input int ra, input int ca, input int rb,
                                        input int cb);
    lsw_in_t req;
    req       = IN_W'($urandom);
    req.mode  = CMD_TRACE;
    req.row_a = COORD_W'(ra);
    req.col_a = COORD_W'(ca);
    req.row_b = COORD_W'(rb);
    req.col_b = COORD_W'(cb);
    return req;
  endfunction

  function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] v);
    int n;
    n = int'(v) + int'($urandom_range(10)) - 5;
    return COORD_W'((n < 0) ? 0 : ((n > GRID_SIZE_DEF - 1) ? GRID_SIZE_DEF - 1 : n));
  endfunction

  // Random mix: wall writes, long lines, short lines and lines aimed at the
  // most recently written cell so that walls get hit often.
  function automatic lsw_in_t random_req();
    lsw_in_t req;
    int      pick;
    req  = IN_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      req.mode     = CMD_WRITE;
      req.wall_bit = ($urandom_range(99) < 65);
      last_wr_row  = req.row_a;
      last_wr_col  = req.col_a;
    end else begin
      req.mode = CMD_TRACE;
      if (pick < 50) begin
        req.row_b = near_coord(req.row_a);
        req.col_b = near_coord(req.col_a);
      end else if (pick < 60) begin
        req.row_b = last_wr_row;
        req.col_b = last_wr_col;
      end
    end
    return req;
  endfunction

  // Offer one request, with random idle cycles first, and wait for acceptance.
  task automatic send_req(input lsw_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (req.mode == CMD_TRACE) begin
      traces_sent++;
    end else begin
      writes_sent++;
    end
  endtask

  // Stop offering and wait until every owed cell has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (cells_owed != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);

    // Directed part: extremes, tie rule in all four cases, walls at start,
    // middle and end, cleared walls and single-cell lines.
    send_req(trace_req(0, 0, 63, 63));
    send_req(trace_req(63, 63, 0, 0));
    send_req(trace_req(0, 63, 0, 0));
    send_req(trace_req(0, 0, 63, 0));
    send_req(trace_req(7, 7, 7, 7));
    send_req(trace_req(0, 0, 1, 2));
    send_req(trace_req(0, 2, 1, 0));
    send_req(trace_req(0, 0, 2, 1));
    send_req(trace_req(2, 0, 0, 1));
    send_req(wall_req(10, 20, 1'b1));
    send_req(trace_req(10, 20, 30, 30));
    send_req(wall_req(12, 40, 1'b1));
    send_req(trace_req(12, 30, 12, 40));
    send_req(wall_req(20, 25, 1'b1));
    send_req(trace_req(20, 20, 20, 30));
    send_req(wall_req(10, 20, 1'b0));
    send_req(trace_req(10, 20, 10, 10));
    send_req(wall_req(63, 63, 1'b1));
    send_req(trace_req(0, 0, 63, 63));
    send_req(trace_req(63, 63, 63, 63));
    send_req(wall_req(0, 0, 1'b1));
    send_req(trace_req(0, 0, 0, 0));
    send_req(wall_req(0, 0, 1'b0));
    send_req(trace_req(63, 0, 0, 63));
    send_req(wall_req(63, 63, 1'b0));
    drain();

    // Random part in three idle mixes; the second opens with a long output hold
    // while requests keep coming, so the front queue fills and stalls.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 23 : ((phase == 1) ? 48 : 0);
      recv_idle_pct = (phase == 0) ? 48 : ((phase == 1) ? 23 : 0);
      if (phase == 1) begin
        hold_output = 1'b1;
      end
      repeat (PHASE_ITEMS) send_req(random_req());
      drain();
    end

    $display("Sent %0d requests (%0d traces, %0d wall writes), checked %0d cells.",
             traces_sent + writes_sent, traces_sent, writes_sent, cells_checked);
    $display("Idle mixes 23/48, 48/23 and none, with one %0d-cycle output hold.",
             HOLD_CYCLES);
    if (mismatch_count == 0 && cells_owed == 0) begin
      $display("line_of_sight_walker_unit_tb: clean");
    end else begin
      $display("line_of_sight_walker_unit_tb: errors");
    end
    $finish;
  end

endmodule
